// File: hdl/csv_field_splitter_assert.svh
// Assertion macros used by the checker of the CSV field splitter.
`ifndef CSV_FIELD_SPLITTER_ASSERT_SVH
`define CSV_FIELD_SPLITTER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CSVFS_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("csv field splitter check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define CSVFS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("csv field splitter check failed");

`endif

// File: hdl/csvfs_pkg.sv
package csvfs_pkg;

  // Sizes of the block.
  localparam int MAX_FIELDS     = 64;
  localparam int FIELD_BITS     = $clog2(MAX_FIELDS);
  localparam int NF_BITS        = 7;
  localparam int MASK_BITS      = 64;
  localparam int ROW_COUNT_BITS = 40;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;

  // Fixed characters.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  // Register reset values.
  localparam logic [7:0]         RST_QUOTE  = 8'd34;
  localparam logic [7:0]         RST_SEP    = 8'd44;
  localparam logic [7:0]         RST_RECORD = 8'd10;
  localparam logic [NF_BITS-1:0] RST_NUM    = NF_BITS'(1);

  // Input operations.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_QUOTE_CHAR     = 3'd0,
    REG_SEPARATOR_CHAR = 3'd1,
    REG_RECORD_CHAR    = 3'd2,
    REG_NUM_FIELDS     = 3'd3,
    REG_SKIP_HEADER    = 3'd4,
    REG_LOAD_MASK      = 3'd5
  } cfg_reg_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_CONTENT   = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ERROR     = 2'd2,
    KIND_SUMMARY   = 2'd3
  } kind_t;

  // Error codes.
  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_BAD_ESCAPE  = 2'd1,
    ERR_AFTER_QUOTE = 2'd2,
    ERR_INCOMPLETE  = 2'd3
  } err_t;

endpackage

// File: hdl/csvfs_in_if.sv
interface csvfs_in_if import csvfs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink (input valid, input operation, input data_byte, output ready);
endinterface

// File: hdl/csvfs_out_if.sv
interface csvfs_out_if import csvfs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [7:0]                out_byte;
  logic [FIELD_BITS-1:0]     field_index;
  logic                      row_end;
  logic [1:0]                error_code;
  logic [ROW_COUNT_BITS-1:0] row_count;

  modport source (output valid, output kind, output out_byte, output field_index,
                  output row_end, output error_code, output row_count, input ready);
  modport sink (input valid, input kind, input out_byte, input field_index,
                input row_end, input error_code, input row_count, output ready);
endinterface

// File: hdl/csvfs_cfg_if.sv
interface csvfs_cfg_if import csvfs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/csv_field_splitter.sv
// CSV field splitter: takes one byte (or an end-of-input marker) per beat and gives at most
// one result per beat: a content byte, a field end, an error or an end summary. The block
// sustains one input beat per clock cycle while the output side is not stalled; a beat goes
// through an input register and then through the parse logic into the result register. The
// rate rests on the update of the parser state (field flags, field index, record counter),
// made as each beat leaves the input register. Configuration registers are written through
// the cfg channel, which is always ready, and must only be written while no beat is in
// flight. After an error, data beats give no results until reset; end beats still give the
// summary.
module csv_field_splitter import csvfs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  csvfs_in_if.sink     din,
  csvfs_out_if.source  dout,
  csvfs_cfg_if.sink    cfg
);

  // Configuration registers.
  logic [7:0]           quote_char;
  logic [7:0]           separator_char;
  logic [7:0]           record_char;
  logic [NF_BITS-1:0]   num_fields;
  logic                 skip_header;
  logic [MASK_BITS-1:0] load_mask;

  // Parser state.
  logic                      in_field, in_field_next;
  logic                      quoted_field, quoted_field_next;
  logic                      escape_active, escape_active_next;
  logic                      expect_delimiter, expect_delimiter_next;
  logic                      failed, failed_next;
  logic [FIELD_BITS-1:0]     current_field, current_field_next;
  logic [ROW_COUNT_BITS-1:0] records_seen, records_seen_next;

  // Input register.
  logic       s1_valid;
  logic       s1_op;
  logic [7:0] s1_byte;

  // Result register.
  logic                      out_valid;
  kind_t                     out_kind;
  logic [7:0]                out_byte;
  logic [FIELD_BITS-1:0]     out_field;
  logic                      out_row_end;
  err_t                      out_err;
  logic [ROW_COUNT_BITS-1:0] out_rows;

  // Result computed for the beat in the input register.
  logic                      res_valid;
  kind_t                     res_kind;
  logic [7:0]                res_byte;
  logic [FIELD_BITS-1:0]     res_field;
  logic                      res_row_end;
  err_t                      res_err;
  logic [ROW_COUNT_BITS-1:0] res_rows;

  logic               out_free;
  logic               advance;
  logic [NF_BITS-1:0] eff_fields;
  logic               at_last;
  logic               term;
  logic               vis;
  logic               escapes_on;
  logic               esc_quote;
  logic               do_end;
  logic               do_content;
  logic               do_fail;
  err_t               fail_code;

  // Handshake: the input register moves on whenever the result register can take a beat.
  assign out_free  = !out_valid || dout.ready;
  assign advance   = s1_valid && out_free;
  assign din.ready = !s1_valid || out_free;
  assign cfg.ready = 1'b1;

  // Field position and visibility of the current field.
  always_comb begin
    if (num_fields == '0) begin
      eff_fields = NF_BITS'(1);
    end else if (num_fields > NF_BITS'(MAX_FIELDS)) begin
      eff_fields = NF_BITS'(MAX_FIELDS);
    end else begin
      eff_fields = num_fields;
    end
  end

  assign at_last    = ({1'b0, current_field} + NF_BITS'(1)) >= eff_fields;
  assign term       = at_last ? (s1_byte == record_char) : (s1_byte == separator_char);
  assign vis        = !(skip_header && records_seen == '0) && load_mask[current_field];
  assign escapes_on = separator_char != CH_TAB;

  // Parse step: decide what the byte does and the next parser state.
  always_comb begin
    in_field_next         = in_field;
    quoted_field_next     = quoted_field;
    escape_active_next    = escape_active;
    expect_delimiter_next = expect_delimiter;
    failed_next           = failed;
    current_field_next    = current_field;
    records_seen_next     = records_seen;
    esc_quote             = 1'b0;
    do_end                = 1'b0;
    do_content            = 1'b0;
    do_fail               = 1'b0;
    fail_code             = ERR_NONE;

    res_valid   = 1'b0;
    res_kind    = KIND_CONTENT;
    res_byte    = '0;
    res_field   = '0;
    res_row_end = 1'b0;
    res_err     = ERR_NONE;
    res_rows    = '0;

    if (s1_op == OP_END) begin
      // End beat: report the stream status and leave the state alone.
      res_valid = 1'b1;
      res_kind  = KIND_SUMMARY;
      if (failed || in_field || expect_delimiter || current_field != '0) begin
        res_err = ERR_INCOMPLETE;
      end
      if (skip_header && records_seen != '0) begin
        res_rows = records_seen - ROW_COUNT_BITS'(1);
      end else begin
        res_rows = records_seen;
      end
    end else if (!failed) begin
      if (expect_delimiter) begin
        // Byte after a closing quote must end the field.
        if (!term) begin
          do_fail   = 1'b1;
          fail_code = ERR_AFTER_QUOTE;
        end else begin
          expect_delimiter_next = 1'b0;
          do_end                = 1'b1;
        end
      end else if (escapes_on && escape_active && s1_byte != CH_BSLASH &&
                   s1_byte != CH_DQUOTE) begin
        do_fail   = 1'b1;
        fail_code = ERR_BAD_ESCAPE;
      end else begin
        // Escape tracking.
        if (escapes_on) begin
          if (s1_byte == CH_BSLASH) begin
            escape_active_next = !escape_active;
          end
          if (s1_byte == CH_DQUOTE && escape_active) begin
            esc_quote          = 1'b1;
            escape_active_next = 1'b0;
          end
        end
        // Field framing.
        if (!in_field) begin
          if (s1_byte == quote_char) begin
            in_field_next     = 1'b1;
            quoted_field_next = 1'b1;
          end else if (term) begin
            do_end = 1'b1;
          end else begin
            in_field_next     = 1'b1;
            quoted_field_next = 1'b0;
            do_content        = 1'b1;
          end
        end else if (quoted_field) begin
          if (s1_byte == quote_char && !esc_quote) begin
            in_field_next         = 1'b0;
            quoted_field_next     = 1'b0;
            expect_delimiter_next = 1'b1;
          end else begin
            do_content = 1'b1;
          end
        end else if (term) begin
          do_end = 1'b1;
        end else begin
          do_content = 1'b1;
        end
      end
    end

    // Error result, always shown.
    if (do_fail) begin
      failed_next = 1'b1;
      res_valid   = 1'b1;
      res_kind    = KIND_ERROR;
      res_field   = current_field;
      res_err     = fail_code;
    end

    // Content byte of a visible field.
    if (do_content) begin
      res_valid = vis;
      res_kind  = KIND_CONTENT;
      res_byte  = s1_byte;
      res_field = current_field;
    end

    // Field end: step to the next field or close the record.
    if (do_end) begin
      in_field_next     = 1'b0;
      quoted_field_next = 1'b0;
      if (at_last) begin
        current_field_next = '0;
        if (records_seen != '1) begin
          records_seen_next = records_seen + ROW_COUNT_BITS'(1);
        end
      end else begin
        current_field_next = current_field + FIELD_BITS'(1);
      end
      res_valid   = vis;
      res_kind    = KIND_FIELD_END;
      res_field   = current_field;
      res_row_end = at_last;
    end
  end

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_char     <= RST_QUOTE;
      separator_char <= RST_SEP;
      record_char    <= RST_RECORD;
      num_fields     <= RST_NUM;
      skip_header    <= 1'b0;
      load_mask      <= '1;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_QUOTE_CHAR:     quote_char     <= cfg.data[7:0];
        REG_SEPARATOR_CHAR: separator_char <= cfg.data[7:0];
        REG_RECORD_CHAR:    record_char    <= cfg.data[7:0];
        REG_NUM_FIELDS:     num_fields     <= cfg.data[NF_BITS-1:0];
        REG_SKIP_HEADER:    skip_header    <= cfg.data[0];
        REG_LOAD_MASK:      load_mask      <= cfg.data[MASK_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      s1_op   <= din.operation;
      s1_byte <= din.data_byte;
    end
  end

  // Parser state update, one beat per cycle while the result register can take a beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_field         <= 1'b0;
      quoted_field     <= 1'b0;
      escape_active    <= 1'b0;
      expect_delimiter <= 1'b0;
      failed           <= 1'b0;
      current_field    <= '0;
      records_seen     <= '0;
    end else if (advance) begin
      in_field         <= in_field_next;
      quoted_field     <= quoted_field_next;
      escape_active    <= escape_active_next;
      expect_delimiter <= expect_delimiter_next;
      failed           <= failed_next;
      current_field    <= current_field_next;
      records_seen     <= records_seen_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_kind    <= res_kind;
      out_byte    <= res_byte;
      out_field   <= res_field;
      out_row_end <= res_row_end;
      out_err     <= res_err;
      out_rows    <= res_rows;
    end
  end

  assign dout.valid       = out_valid;
  assign dout.kind        = out_kind;
  assign dout.out_byte    = out_byte;
  assign dout.field_index = out_field;
  assign dout.row_end     = out_row_end;
  assign dout.error_code  = out_err;
  assign dout.row_count   = out_rows;

endmodule

// File: hdl/csvfs_checker.sv
`include "csv_field_splitter_assert.svh"

module csvfs_checker import csvfs_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      din_valid,
  input logic                      din_ready,
  input logic                      dout_valid,
  input logic                      dout_ready,
  input logic [1:0]                dout_kind,
  input logic [7:0]                dout_out_byte,
  input logic [FIELD_BITS-1:0]     dout_field_index,
  input logic                      dout_row_end,
  input logic [1:0]                dout_error_code,
  input logic [ROW_COUNT_BITS-1:0] dout_row_count
);

  // A stalled result beat keeps its contents.
  `CSVFS_ASSERT_NEXT(a_out_hold, dout_valid && !dout_ready, dout_valid && $stable(dout_kind) && $stable(dout_out_byte) && $stable(dout_field_index) && $stable(dout_row_end) && $stable(dout_error_code) && $stable(dout_row_count))

  // A result appearing on an idle output comes from an accepted beat that passed the input register.
  `CSVFS_ASSERT_NOW(a_out_latency, $rose(dout_valid), $past(din_valid && din_ready, 2))

  // Once an error is delivered, no content or field end follows right after.
  `CSVFS_ASSERT_NEXT(a_error_sticky, dout_valid && dout_ready && dout_kind == KIND_ERROR, !(dout_valid && (dout_kind == KIND_CONTENT || dout_kind == KIND_FIELD_END)))

  // An end summary names no field, ends no row, carries no byte and a status code of none or incomplete.
  `CSVFS_ASSERT_NOW(a_summary_shape, dout_valid && dout_kind == KIND_SUMMARY, dout_field_index == '0 && !dout_row_end && dout_out_byte == '0 && (dout_error_code == ERR_NONE || dout_error_code == ERR_INCOMPLETE))

endmodule

bind csv_field_splitter csvfs_checker u_csvfs_checker (
  .clk              (clk),
  .rst              (rst),
  .din_valid        (din.valid),
  .din_ready        (din.ready),
  .dout_valid       (dout.valid),
  .dout_ready       (dout.ready),
  .dout_kind        (dout.kind),
  .dout_out_byte    (dout.out_byte),
  .dout_field_index (dout.field_index),
  .dout_row_end     (dout.row_end),
  .dout_error_code  (dout.error_code),
  .dout_row_count   (dout.row_count)
);

// File: tb/sv/csv_split_checker.sv
`timescale 1ns / 1ps

// Watches the three channels of the CSV field splitter. It keeps its own copy of the
// registers and the parse state, works out the result of every accepted input beat,
// and compares every accepted result beat with the oldest outstanding one.
module csv_split_checker import csvfs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  csvfs_in_if   din,
  csvfs_out_if  dout,
  csvfs_cfg_if  cfg,
  output int    mismatches,
  output int    items_waiting
);

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    kind_t                     kind;
    logic [7:0]                out_byte;
    logic [FIELD_BITS-1:0]     field_index;
    logic                      row_end;
    err_t                      error_code;
    logic [ROW_COUNT_BITS-1:0] row_count;
  } split_item_t;

  // Register copies.
  logic [7:0]          quote_r;
  logic [7:0]          sep_r;
  logic [7:0]          rec_r;
  logic [NF_BITS-1:0]  nfields_r;
  logic                skip_r;
  logic [MASK_BITS-1:0] mask_r;

  // Parse state.
  logic                      in_fld;
  logic                      quoted;
  logic                      esc_on;
  logic                      await_delim;
  logic                      stuck;
  logic [FIELD_BITS-1:0]     fld;
  logic [ROW_COUNT_BITS-1:0] rows;

  split_item_t outstanding[$];

  // The current field is the last one of the record, also when it lies past the end.
  function automatic logic last_field();
    logic [NF_BITS-1:0] eff;
    if (nfields_r == 0) eff = NF_BITS'(1);
    else if (nfields_r > MAX_FIELDS) eff = NF_BITS'(MAX_FIELDS);
    else eff = nfields_r;
    return ({1'b0, fld} + NF_BITS'(1)) >= eff;
  endfunction

  function automatic logic ends_field(input logic [7:0] b);
    return last_field() ? (b == rec_r) : (b == sep_r);
  endfunction

  // Masked fields are hidden, and so is every field of the header record when it is skipped.
  function automatic logic shown();
    if (skip_r && rows == 0) return 1'b0;
    return mask_r[fld];
  endfunction

  function automatic bit raise_error(input err_t code, output split_item_t res);
    stuck = 1'b1;
    res = '0;
    res.kind = KIND_ERROR;
    res.field_index = fld;
    res.error_code = code;
    return 1'b1;
  endfunction

  function automatic bit emit_byte(input logic [7:0] b, output split_item_t res);
    res = '0;
    res.kind = KIND_CONTENT;
    res.out_byte = b;
    res.field_index = fld;
    return shown();
  endfunction

  function automatic bit close_field(output split_item_t res);
    logic                  vis;
    logic                  last;
    logic [FIELD_BITS-1:0] idx;
    vis = shown();
    last = last_field();
    idx = fld;
    in_fld = 1'b0;
    quoted = 1'b0;
    if (last) begin
      if (rows != {ROW_COUNT_BITS{1'b1}}) rows = rows + 1'b1;
      fld = '0;
    end else begin
      fld = fld + 1'b1;
    end
    res = '0;
    res.kind = KIND_FIELD_END;
    res.field_index = idx;
    res.row_end = last;
    return vis;
  endfunction

  // Advances the parse state by one input beat; returns 1 when the beat gives a result.
  function automatic bit next_result(input logic op, input logic [7:0] b,
                                     output split_item_t res);
    logic                      esc_quote;
    logic [ROW_COUNT_BITS-1:0] n;
    res = '0;
    esc_quote = 1'b0;
    if (op == OP_END) begin
      n = rows;
      if (skip_r && n != 0) n = n - 1'b1;
      res.kind = KIND_SUMMARY;
      res.error_code = (stuck || in_fld || await_delim || fld != 0) ? ERR_INCOMPLETE : ERR_NONE;
      res.row_count = n;
      return 1'b1;
    end
    if (stuck) return 1'b0;

    // After a closing quote only the proper delimiter may follow.
    if (await_delim) begin
      if (!ends_field(b)) return raise_error(ERR_AFTER_QUOTE, res);
      await_delim = 1'b0;
      return close_field(res);
    end

    // Escape tracking is off in tab-separated mode.
    if (sep_r != CH_TAB) begin
      if (esc_on && b != CH_BSLASH && b != CH_DQUOTE) return raise_error(ERR_BAD_ESCAPE, res);
      if (b == CH_BSLASH) esc_on = !esc_on;
      if (b == CH_DQUOTE && esc_on) begin
        esc_quote = 1'b1;
        esc_on = 1'b0;
      end
    end

    if (!in_fld) begin
      if (b == quote_r) begin
        in_fld = 1'b1;
        quoted = 1'b1;
        return 1'b0;
      end
      if (ends_field(b)) return close_field(res);
      in_fld = 1'b1;
      quoted = 1'b0;
      return emit_byte(b, res);
    end
    if (quoted) begin
      if (b == quote_r && !esc_quote) begin
        in_fld = 1'b0;
        quoted = 1'b0;
        await_delim = 1'b1;
        return 1'b0;
      end
      return emit_byte(b, res);
    end
    if (ends_field(b)) return close_field(res);
    return emit_byte(b, res);
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endtask

  // Beats are sampled at the rising edge, before the edge's updates land.
  always @(posedge clk) begin : watch
    split_item_t want;
    split_item_t got;
    if (rst) begin
      quote_r = RST_QUOTE;
      sep_r = RST_SEP;
      rec_r = RST_RECORD;
      nfields_r = RST_NUM;
      skip_r = 1'b0;
      mask_r = '1;
      in_fld = 1'b0;
      quoted = 1'b0;
      esc_on = 1'b0;
      await_delim = 1'b0;
      stuck = 1'b0;
      fld = '0;
      rows = '0;
      mismatches = 0;
      outstanding.delete();
    end else begin
      // Register writes.
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_QUOTE_CHAR:     quote_r = cfg.data[7:0];
          REG_SEPARATOR_CHAR: sep_r = cfg.data[7:0];
          REG_RECORD_CHAR:    rec_r = cfg.data[7:0];
          REG_NUM_FIELDS:     nfields_r = cfg.data[NF_BITS-1:0];
          REG_SKIP_HEADER:    skip_r = cfg.data[0];
          REG_LOAD_MASK:      mask_r = cfg.data[MASK_BITS-1:0];
          default: ;
        endcase
      end

      // Input beats.
      if (din.valid && din.ready) begin
        if (next_result(din.operation, din.data_byte, want)) outstanding.push_back(want);
      end

      // Result beats.
      if (dout.valid && dout.ready) begin
        got.kind = kind_t'(dout.kind);
        got.out_byte = dout.out_byte;
        got.field_index = dout.field_index;
        got.row_end = dout.row_end;
        got.error_code = err_t'(dout.error_code);
        got.row_count = dout.row_count;
        if (outstanding.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result beat with none expected: expected nothing, actual %0h",
                     $time, got);
          end
        end else begin
          want = outstanding.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("out_byte", want.out_byte, got.out_byte);
          check_field("field_index", want.field_index, got.field_index);
          check_field("row_end", want.row_end, got.row_end);
          check_field("error_code", want.error_code, got.error_code);
          check_field("row_count", want.row_count, got.row_count);
        end
      end
    end
    items_waiting <= outstanding.size();
  end

endmodule

// File: tb/sv/tb_csv_field_splitter.sv
`timescale 1ns / 1ps

module tb_csv_field_splitter;
  import csvfs_pkg::*;

  localparam int         PHASES         = 9;
  localparam int         PHASE_BEATS    = 108;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         DRAIN_CYCLES   = 8;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam logic [7:0] COMMA          = 8'h2C;
  localparam logic [7:0] SEMI           = 8'h3B;
  localparam logic [7:0] APOS           = 8'h27;
  localparam logic [7:0] NEWLINE        = 8'h0A;
  localparam logic [7:0] CR             = 8'h0D;

  logic clk = 1'b0;
  logic rst = 1'b1;

  csvfs_in_if  in_ch ();
  csvfs_out_if out_ch ();
  csvfs_cfg_if cfg_ch ();

  int check_errors;
  int items_waiting;
  int quiet_cycles = 0;
  int beats = 0;

  // Stimulus controls.
  bit calm = 1'b0;
  bit noise_on = 1'b0;
  bit hold_req = 1'b0;

  // Settings the byte generator works with, and the field it is at.
  logic [7:0]         cur_quote = RST_QUOTE;
  logic [7:0]         cur_sep = RST_SEP;
  logic [7:0]         cur_rec = RST_RECORD;
  logic [NF_BITS-1:0] cur_nf = RST_NUM;
  int                 tx_field = 0;

  csv_field_splitter u_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch),
    .cfg  (cfg_ch)
  );

  csv_split_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .din           (in_ch),
    .dout          (out_ch),
    .cfg           (cfg_ch),
    .mismatches    (check_errors),
    .items_waiting (items_waiting)
  );

  always #10 clk = ~clk;

  // Known values on every input from time zero.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_DATA;
    in_ch.data_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Ends the run when no channel has moved a beat for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("csv_field_splitter test failed");
        $finish;
      end
    end
  end

  function automatic int tx_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int rx_gap();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, one long hold-off on request.
  initial begin : rx_side
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat (rx_gap()) @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic op, input logic [7:0] b);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    beats++;
  endtask

  // A data byte, now and then preceded by an end beat that leaves the state alone.
  task automatic send_char(input logic [7:0] b);
    if (noise_on && $urandom_range(0, 29) == 0) send_beat(OP_END, 8'($urandom()));
    send_beat(OP_DATA, b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index, input logic [63:0] value,
                           input int bits);
    logic [63:0] word;
    word = {$urandom(), $urandom()};
    if (bits < 64) word = (word & ~((64'd1 << bits) - 64'd1)) | value;
    else word = value;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= word;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] q, input logic [7:0] s, input logic [7:0] r,
                            input logic [NF_BITS-1:0] nf, input logic skip,
                            input logic [63:0] mask);
    cur_quote = q;
    cur_sep = s;
    cur_rec = r;
    cur_nf = nf;
    write_reg(REG_QUOTE_CHAR, q, 8);
    write_reg(REG_SEPARATOR_CHAR, s, 8);
    write_reg(REG_RECORD_CHAR, r, 8);
    write_reg(REG_NUM_FIELDS, nf, NF_BITS);
    write_reg(REG_SKIP_HEADER, skip, 1);
    write_reg(REG_LOAD_MASK, mask, 64);
  endtask

  // Waits until every expected result has arrived and the pipeline has emptied.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (items_waiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A byte that has no special meaning under the current settings.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == cur_quote || b == cur_sep || b == cur_rec || b == CH_BSLASH || b == CH_DQUOTE);
    return b;
  endfunction

  // A delimiter character for a random setting, clear of the fixed characters.
  function automatic logic [7:0] pick_char(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_BSLASH || c == CH_DQUOTE || c == CH_TAB || c == a || c == b);
    return c;
  endfunction

  // One well-formed field with random content, closed by its proper delimiter.
  task automatic send_field();
    int   n;
    int   len;
    int   r;
    logic last;
    logic quoted;
    n = (cur_nf == 0) ? 1 : ((cur_nf > MAX_FIELDS) ? MAX_FIELDS : int'(cur_nf));
    last = (tx_field + 1 >= n);
    quoted = ($urandom_range(0, 3) == 0);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
    if (quoted) send_char(cur_quote);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0 && cur_sep != CH_TAB) begin
        // Escape pairs: an escaped backslash or an escaped double quote.
        send_char(CH_BSLASH);
        send_char($urandom_range(0, 1) ? CH_BSLASH : CH_DQUOTE);
      end else if (r == 1 && quoted) begin
        send_char($urandom_range(0, 1) ? cur_sep : cur_rec);
      end else if (r == 2 && !quoted && i > 0) begin
        send_char(cur_quote);
      end else if (r == 3 && cur_sep == CH_TAB) begin
        send_char(CH_BSLASH);
      end else if (r == 4 && cur_sep == CH_TAB && cur_quote != CH_DQUOTE) begin
        send_char(CH_DQUOTE);
      end else begin
        send_char(plain_byte());
      end
    end
    if (quoted) send_char(cur_quote);
    send_char(last ? cur_rec : cur_sep);
    tx_field = last ? 0 : tx_field + 1;
  endtask

  initial begin : stimulus
    int               goal;
    logic [7:0]       q;
    logic [7:0]       s;
    logic [7:0]       r;
    logic [NF_BITS-1:0] nf;
    logic [63:0]      mask;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: three fields per record, header skipped.
    set_config(CH_DQUOTE, COMMA, NEWLINE, 3, 1'b1, '1);
    send_text(",,\n");
    send_text("\"\\\"\",");
    send_text("\\\\x,");
    send_char(8'hFF);
    send_char(8'h00);
    send_char(NEWLINE);
    send_beat(OP_END, 8'h00);
    // End beats inside a record: mid-record and with the delimiter after a closing quote pending.
    send_text("a,");
    send_beat(OP_END, 8'hFF);
    send_text("\"b\"");
    send_beat(OP_END, 8'h5A);
    send_text(",\n");
    tx_field = 0;
    wait_idle();

    // Random part: phases of well-formed fields under different settings.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(CH_DQUOTE, COMMA, NEWLINE, 64, 1'b1, '1);
        1: set_config(APOS, CH_TAB, CR, 1, 1'b0, {$urandom(), $urandom()});
        2: set_config(CH_DQUOTE, SEMI, NEWLINE, 5, 1'b1, 64'h0);
        3: set_config(8'h00, 8'hFF, 8'h01, 0, 1'b0, {$urandom(), $urandom()});
        4: set_config(8'hFF, 8'h00, CH_TAB, 127, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
        default: begin
          q = $urandom_range(0, 1) ? CH_DQUOTE : pick_char(CH_DQUOTE, CH_DQUOTE);
          s = ($urandom_range(0, 2) == 0) ? CH_TAB : pick_char(q, q);
          r = pick_char(q, s);
          nf = ($urandom_range(0, 3) == 0) ? NF_BITS'($urandom_range(1, 64))
                                           : NF_BITS'($urandom_range(1, 8));
          mask = ($urandom_range(0, 3) == 0) ? '1 : {$urandom(), $urandom()};
          set_config(q, s, r, nf, 1'($urandom_range(0, 1)), mask);
        end
      endcase
      // Indexes past the last register have no effect.
      if (p == 1) begin
        write_reg(REG_LOAD_MASK + 1, {$urandom(), $urandom()}, 64);
        write_reg(REG_LOAD_MASK + 2, {$urandom(), $urandom()}, 64);
      end
      calm = (p == 3) || ($urandom_range(0, 4) == 0);
      // The wide records of the first phase fill the block while results are held off.
      if (p == 0) hold_req = 1'b1;
      noise_on = 1'b1;
      goal = beats + PHASE_BEATS;
      while (beats < goal) send_field();
      wait_idle();
    end

    // A stream error, which is sticky: data beats after it give nothing.
    noise_on = 1'b0;
    calm = 1'b0;
    set_config(CH_DQUOTE, COMMA, NEWLINE, 3, 1'b0, '1);
    send_beat(OP_END, 8'h00);
    if ($urandom_range(0, 1)) begin
      send_char(CH_BSLASH);
      send_char(plain_byte());
    end else begin
      send_char(CH_DQUOTE);
      send_char(plain_byte());
      send_char(CH_DQUOTE);
      send_char(plain_byte());
    end
    send_char(plain_byte());
    send_char(COMMA);
    send_char(NEWLINE);
    send_beat(OP_END, 8'h00);
    wait_idle();

    if (check_errors == 0) begin
      $display("csv_field_splitter test passed");
    end else begin
      $display("csv_field_splitter test failed");
    end
    $finish;
  end

endmodule
